// ----- rtl/ddrt_pkg.sv -----
// package: table depth, widths, status codes, entry record and controller states
package ddrt_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 48;
  localparam int RecW = 2 + 32 * 9;

  localparam logic [1:0] StatusUpdated = 2'd0;
  localparam logic [1:0] StatusCreated = 2'd1;
  localparam logic [1:0] StatusDropped = 2'd2;

  localparam logic [1:0] RegRunGap = 2'd0;
  localparam logic [1:0] RegSustRun = 2'd1;
  localparam logic [1:0] RegSustMin = 2'd2;

  localparam logic [31:0] U32Max = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] count;
    logic [31:0] first_t;
    logic [31:0] last_t;
    logic [31:0] run_begin;
    logic [31:0] best_run;
    logic [31:0] run_count;
    logic [31:0] best_count;
    logic [31:0] encounters;
    logic [31:0] gap;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == U32Max) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/ddrt_ram.sv -----
// generic single-port ram with registered read
module ddrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/device_dwell_run_tracker.sv -----
// device dwell run tracker: table lookup by linear search and run statistics update
//
//  channel  signals                                         handshake
//  config   cfg_we cfg_index cfg_data                       write when cfg_we
//  item in  device_address device_class timestamp_ms        start && !busy
//  result   status entry_index stored_class ... sustained   done strobe, one cycle
//
// a miss scans every entry in use and a hit stops at the matching key, so a hit
// finishes sooner; the done strobe is registered from the update state after read.
// the key memory is read one address a cycle. reset empties the table at once
// through the fill count. results cannot be stalled; busy is high from accept
// through the cycle of the done strobe.
module device_dwell_run_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [47:0]                device_address,
  input  logic [1:0]                 device_class,
  input  logic [31:0]                timestamp_ms,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [9:0]                 entry_index,
  output logic [1:0]                 stored_class,
  output logic [31:0]                sighting_total,
  output logic [31:0]                encounter_total,
  output logic [31:0]                current_run_count,
  output logic [31:0]                longest_run_ms,
  output logic [31:0]                longest_run_count,
  output logic [31:0]                largest_gap_ms,
  output logic [31:0]                first_seen_ms,
  output logic [31:0]                last_seen_ms,
  output logic                       sustained
);
  import ddrt_pkg::*;

  state_t state, state_next;
  logic [31:0] run_gap, sust_run;
  logic [15:0] sust_min;
  logic [CntW-1:0] used, scan, scan_next;
  logic [KeyW-1:0] key_q;
  logic [1:0] cls_q;
  logic [31:0] ts_q;
  logic [IdxW-1:0] slot;
  logic is_new;
  logic key_valid;

  logic [IdxW-1:0] key_addr, rec_addr;
  logic key_we, rec_we;
  logic [KeyW-1:0] key_rd;
  rec_t rec_rd, rec_wr, rec_out;

  ddrt_ram #(.Width(KeyW), .Depth(TableDepth)) u_keys (
    .clk, .we(key_we), .addr(key_addr), .wdata(key_q), .rdata(key_rd)
  );
  ddrt_ram #(.Width(RecW), .Depth(TableDepth)) u_recs (
    .clk, .we(rec_we), .addr(rec_addr), .wdata(rec_wr), .rdata(rec_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run_gap <= 32'd60000;
      sust_run <= 32'd120000;
      sust_min <= 16'd8;
      used <= '0;
      done <= 1'b0;
      key_valid <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_UPDATE);
      if (cfg_we) begin
        case (cfg_index)
          RegRunGap:  run_gap <= cfg_data;
          RegSustRun: sust_run <= cfg_data;
          RegSustMin: sust_min <= cfg_data[15:0];
          default: ;
        endcase
      end
      key_valid <= (state == ST_SEARCH) && (scan < used) && !(key_valid && key_rd == key_q);
      if (state == ST_UPDATE && is_new && used < CntW'(TableDepth)) used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    if (start && !busy) begin
      key_q <= device_address;
      cls_q <= device_class;
      ts_q <= timestamp_ms;
    end
    if (state == ST_SEARCH) begin
      if (key_valid && key_rd == key_q) begin
        slot <= IdxW'(scan - 1'b1);
        is_new <= 1'b0;
      end else begin
        slot <= used[IdxW-1:0];
        is_new <= 1'b1;
      end
    end
    if (state == ST_UPDATE) begin
      status <= (is_new && used >= CntW'(TableDepth)) ? StatusDropped
              : (is_new ? StatusCreated : StatusUpdated);
      if (is_new && used >= CntW'(TableDepth)) begin
        entry_index <= '0;
        rec_out <= '0;
        sustained <= 1'b0;
      end else begin
        entry_index <= 10'(slot);
        rec_out <= rec_wr;
        sustained <= (rec_wr.best_run >= sust_run) &&
                     (rec_wr.best_count >= {16'd0, sust_min});
      end
    end
  end

  // search: key read issued at scan, compared in the next cycle
  logic hit;
  assign hit = key_valid && key_rd == key_q;

  always_comb begin
    state_next = state;
    scan_next = scan;
    key_we = 1'b0;
    rec_we = 1'b0;
    key_addr = scan[IdxW-1:0];
    rec_addr = slot;
    case (state)
      ST_IDLE: begin
        scan_next = '0;
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit || (!key_valid && scan >= used)) begin
          state_next = ST_READ;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        rec_we = !(is_new && used >= CntW'(TableDepth));
        key_we = rec_we && is_new;
        key_addr = slot;
        state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [31:0] gap, run_len, rc;
  always_comb begin
    rec_wr = rec_rd;
    gap = (ts_q > rec_rd.last_t) ? ts_q - rec_rd.last_t : 32'd0;
    run_len = ts_q - rec_rd.run_begin;
    rc = sat_inc(rec_rd.run_count);
    if (is_new) begin
      rec_wr.cls = cls_q;
      rec_wr.count = 32'd1;
      rec_wr.first_t = ts_q;
      rec_wr.last_t = ts_q;
      rec_wr.run_begin = ts_q;
      rec_wr.best_run = '0;
      rec_wr.run_count = 32'd1;
      rec_wr.best_count = 32'd1;
      rec_wr.encounters = 32'd1;
      rec_wr.gap = '0;
    end else begin
      if (gap > rec_rd.gap) rec_wr.gap = gap;
      if (gap > run_gap) begin
        rec_wr.encounters = sat_inc(rec_rd.encounters);
        rec_wr.run_begin = ts_q;
        rec_wr.run_count = 32'd1;
      end else begin
        rec_wr.run_count = rc;
        if (ts_q >= rec_rd.run_begin && run_len >= rec_rd.best_run) begin
          rec_wr.best_run = run_len;
          rec_wr.best_count = rc;
        end
      end
      if (ts_q > rec_rd.last_t) rec_wr.last_t = ts_q;
      if (ts_q < rec_rd.first_t) rec_wr.first_t = ts_q;
      rec_wr.count = sat_inc(rec_rd.count);
    end
  end

  assign busy = (state != ST_IDLE);
  assign stored_class = rec_out.cls;
  assign sighting_total = rec_out.count;
  assign encounter_total = rec_out.encounters;
  assign current_run_count = rec_out.run_count;
  assign longest_run_ms = rec_out.best_run;
  assign longest_run_count = rec_out.best_count;
  assign largest_gap_ms = rec_out.gap;
  assign first_seen_ms = rec_out.first_t;
  assign last_seen_ms = rec_out.last_t;

  a_fill: assert property (@(posedge clk) disable iff (rst) used <= CntW'(TableDepth))
    else $error("fill count beyond depth");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == ST_UPDATE)
    else $error("done without update");
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (used != $past(used)) |-> (done && status == StatusCreated))
    else $error("fill count changed without new entry");
endmodule
